// ----- sv/alpha_priority_weighted_blend_macros.svh -----
// Assertion helpers shared by the blend RTL.
// Each macro expects clk and rst_n in the enclosing module.
`ifndef ALPHA_PRIORITY_WEIGHTED_BLEND_MACROS_SVH
`define ALPHA_PRIORITY_WEIGHTED_BLEND_MACROS_SVH

// Same-cycle implication.
`define APWB_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("blend check failed");

// Next-cycle implication.
`define APWB_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("blend check failed");

`endif

// ----- sv/apwb_pkg.sv -----
`default_nettype none

package apwb_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int CHANNELS   = 4;
    localparam int NUM_CH     = 4;
    localparam int ALPHA_CH   = 3;

    localparam int COORD_W    = 12;
    localparam int CH_W       = 8;
    localparam int WEIGHT_W   = 9;
    localparam int DIM_W      = 13;
    localparam int DX_W       = COORD_W + 2;
    localparam int CFG_IDX_W  = 3;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(256);
    // Largest size that a 13-bit register can ask for is 8191.
    localparam logic [DIM_W-1:0] DIM_LIMIT =
        DIM_W'((MAX_DIM > (2 ** DIM_W) - 1) ? (2 ** DIM_W) - 1 : MAX_DIM);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WEIGHT      = 3'd0,
        CFG_HAS_ALPHA   = 3'd1,
        CFG_OFFSET_X    = 3'd2,
        CFG_OFFSET_Y    = 3'd3,
        CFG_DEST_WIDTH  = 3'd4,
        CFG_DEST_HEIGHT = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic [COORD_W-1:0] src_x;
        logic [COORD_W-1:0] src_y;
        logic [CH_W-1:0]    src_c0;
        logic [CH_W-1:0]    src_c1;
        logic [CH_W-1:0]    src_c2;
        logic [CH_W-1:0]    src_c3;
        logic [CH_W-1:0]    dst_c0;
        logic [CH_W-1:0]    dst_c1;
        logic [CH_W-1:0]    dst_c2;
        logic [CH_W-1:0]    dst_c3;
    } pixel_t;

    typedef struct packed {
        logic               write_enable;
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic [CH_W-1:0]    out_c0;
        logic [CH_W-1:0]    out_c1;
        logic [CH_W-1:0]    out_c2;
        logic [CH_W-1:0]    out_c3;
    } result_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0]     weight;
        logic                    has_alpha;
        logic signed [DIM_W-1:0] offset_x;
        logic signed [DIM_W-1:0] offset_y;
        logic [DIM_W-1:0]        dest_width;
        logic [DIM_W-1:0]        dest_height;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        weight:      WEIGHT_ONE,
        has_alpha:   1'b1,
        offset_x:    '0,
        offset_y:    '0,
        dest_width:  DIM_W'(4096),
        dest_height: DIM_W'(4096)
    };

endpackage

`default_nettype wire

// ----- sv/apwb_blend.sv -----
`default_nettype none

module apwb_blend (
    input  apwb_pkg::pixel_t  pixel,
    input  apwb_pkg::cfg_t    cfg,
    output apwb_pkg::result_t result
);
    import apwb_pkg::*;

    localparam int PROD_W = CH_W + WEIGHT_W + 3;
    localparam logic signed [PROD_W-1:0] ROUND = PROD_W'(1 << (CH_W - 1));

    // d + ((s - d) * w + half) >>> 8 equals (s*w + d*(256-w) + half) >> 8
    function automatic logic [CH_W-1:0] blend8(
        input logic [CH_W-1:0]     s_val,
        input logic [CH_W-1:0]     d_val,
        input logic [WEIGHT_W-1:0] wt
    );
        logic signed [CH_W+1:0]  diff;
        logic signed [PROD_W-1:0] prod;
        diff = $signed({2'b00, s_val}) - $signed({2'b00, d_val});
        prod = PROD_W'(diff) * PROD_W'($signed({1'b0, wt}));
        prod = prod + ROUND;
        return d_val + prod[2*CH_W-1:CH_W];
    endfunction

    logic [WEIGHT_W-1:0]    w;
    logic signed [DX_W-1:0] dx;
    logic signed [DX_W-1:0] dy;
    logic [DIM_W-1:0]       wmax;
    logic [DIM_W-1:0]       hmax;
    logic                   in_bounds;
    logic                   alpha_mode;
    logic                   we;
    logic [CH_W-1:0]        s   [NUM_CH];
    logic [CH_W-1:0]        d   [NUM_CH];
    logic [CH_W-1:0]        mix [NUM_CH];
    logic [CH_W-1:0]        r   [NUM_CH];

    always_comb
    begin
        w = (cfg.weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.weight;

        dx = $signed({2'b00, pixel.src_x})
           + $signed({{(DX_W-DIM_W){cfg.offset_x[DIM_W-1]}}, cfg.offset_x});
        dy = $signed({2'b00, pixel.src_y})
           + $signed({{(DX_W-DIM_W){cfg.offset_y[DIM_W-1]}}, cfg.offset_y});

        wmax = (cfg.dest_width  > DIM_LIMIT) ? DIM_LIMIT : cfg.dest_width;
        hmax = (cfg.dest_height > DIM_LIMIT) ? DIM_LIMIT : cfg.dest_height;

        // A nonnegative shifted coordinate never exceeds 13 bits.
        in_bounds = !dx[DX_W-1] && (dx[DIM_W-1:0] < wmax)
                 && !dy[DX_W-1] && (dy[DIM_W-1:0] < hmax);

        alpha_mode = cfg.has_alpha && (CHANNELS == 4);

        s[0] = pixel.src_c0;
        s[1] = pixel.src_c1;
        s[2] = pixel.src_c2;
        s[3] = pixel.src_c3;
        d[0] = pixel.dst_c0;
        d[1] = pixel.dst_c1;
        d[2] = pixel.dst_c2;
        d[3] = pixel.dst_c3;

        for (int i = 0; i < NUM_CH; i++)
        begin
            mix[i] = blend8(s[i], d[i], w);
            r[i]   = d[i];
        end

        we = 1'b1;
        if ((w == '0) || !in_bounds)
        begin
            we = 1'b0;
        end
        else if (alpha_mode)
        begin
            if (w == WEIGHT_ONE)
            begin
                if (s[ALPHA_CH] == '0)
                begin
                    we = 1'b0;
                end
                else
                begin
                    for (int i = 0; i < NUM_CH; i++)
                    begin
                        r[i] = s[i];
                    end
                end
            end
            else if ((s[ALPHA_CH] == '0) || (s[ALPHA_CH] < d[ALPHA_CH]))
            begin
                // weaker source: skip
                we = 1'b0;
            end
            else if ((d[ALPHA_CH] == '0) || (s[ALPHA_CH] > d[ALPHA_CH]))
            begin
                for (int i = 0; i < NUM_CH; i++)
                begin
                    r[i] = s[i];
                end
            end
            else
            begin
                // equal alphas: blend color, keep alpha
                for (int i = 0; i < ALPHA_CH; i++)
                begin
                    r[i] = mix[i];
                end
                r[ALPHA_CH] = s[ALPHA_CH];
            end
        end
        else
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                if (i < CHANNELS)
                begin
                    r[i] = (w == WEIGHT_ONE) ? s[i] : mix[i];
                end
            end
        end

        result = '0;
        if (we)
        begin
            result.write_enable = 1'b1;
            result.out_x  = dx[COORD_W-1:0];
            result.out_y  = dy[COORD_W-1:0];
            result.out_c0 = r[0];
            result.out_c1 = r[1];
            result.out_c2 = r[2];
            result.out_c3 = r[3];
        end
    end

endmodule

`default_nettype wire

// ----- sv/alpha_priority_weighted_blend.sv -----
// Channel   Handshake               Payload
// pixel     pixel_valid/stall       pixel (source pixel, coordinates, destination pixel)
// blend     blend_valid/stall       blend (write enable, destination coordinates, channels)
// cfg       cfg_valid/cfg_ready     cfg_index, cfg_data (register write)
//
// One request per clock while blend_stall is low; a request goes through the input, then the result register.
// The per-pixel shift, bounds check and one 9x10 multiply per channel sit between them.
// rst_n clears both valid flags and loads the register reset values; no clearing pass.
// A stalled result holds; the input register still takes one more request behind it.
// cfg_ready is always high; write registers only while no request is in flight.
`default_nettype none

`include "alpha_priority_weighted_blend_macros.svh"

module alpha_priority_weighted_blend (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                pixel_valid,
    output logic                               pixel_stall,
    input  apwb_pkg::pixel_t                   pixel,
    output logic                               blend_valid,
    input  wire                                blend_stall,
    output apwb_pkg::result_t                  blend,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [apwb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire  [apwb_pkg::DIM_W-1:0]         cfg_data
);
    import apwb_pkg::*;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    s1_valid_reg;
    logic    s1_valid_next;
    pixel_t  s1_pixel_reg;
    logic    s2_valid_reg;
    logic    s2_valid_next;
    result_t s2_result_reg;
    result_t blend_result;
    logic    pixel_accept;
    logic    s2_load;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_WEIGHT:      cfg_next.weight      = cfg_data[WEIGHT_W-1:0];
                CFG_HAS_ALPHA:   cfg_next.has_alpha   = cfg_data[0];
                CFG_OFFSET_X:    cfg_next.offset_x    = $signed(cfg_data);
                CFG_OFFSET_Y:    cfg_next.offset_y    = $signed(cfg_data);
                CFG_DEST_WIDTH:  cfg_next.dest_width  = cfg_data;
                CFG_DEST_HEIGHT: cfg_next.dest_height = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // Advance the result register when it is empty or being taken.
    assign s2_load      = s1_valid_reg && (!s2_valid_reg || !blend_stall);
    assign pixel_stall  = s1_valid_reg && !s2_load;
    assign pixel_accept = pixel_valid && !pixel_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (pixel_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s2_load)
        begin
            s1_valid_next = 1'b0;
        end

        s2_valid_next = s2_valid_reg;
        if (s2_load)
        begin
            s2_valid_next = 1'b1;
        end
        else if (!blend_stall)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg      <= CFG_RESET;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg      <= cfg_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixel_accept)
        begin
            s1_pixel_reg <= pixel;
        end
        if (s2_load)
        begin
            s2_result_reg <= blend_result;
        end
    end

    apwb_blend u_blend (
        .pixel  (s1_pixel_reg),
        .cfg    (cfg_reg),
        .result (blend_result)
    );

    assign blend_valid = s2_valid_reg;
    assign blend       = s2_result_reg;

    `APWB_IMPLY(a_skip_is_zero, blend_valid && !blend.write_enable,
        (blend.out_x == '0) && (blend.out_y == '0) && (blend.out_c0 == '0)
        && (blend.out_c1 == '0) && (blend.out_c2 == '0) && (blend.out_c3 == '0))
    `APWB_IMPLY(a_zero_weight_skips, blend_valid && (cfg_reg.weight == '0),
        !blend.write_enable)
    `APWB_IMPLY(a_write_in_bounds, blend_valid && blend.write_enable,
        ({1'b0, blend.out_x} < cfg_reg.dest_width)
        && ({1'b0, blend.out_y} < cfg_reg.dest_height))
    `APWB_IMPLY(a_full_pipe_stalls, s1_valid_reg && blend_valid && blend_stall,
        pixel_stall)
    `APWB_NEXT(a_request_lands, pixel_valid && !pixel_stall, s1_valid_reg)

endmodule

`default_nettype wire
